>>> rtl/core/lsmp_pkg.sv
// ----------------------------------------------------------------------------
// lsmp_pkg: shared types and constants of the laser scan median filter
// Position codes, register indexes and the queue geometry used by the
// filter core, the output queue and the top level.
// ----------------------------------------------------------------------------
package lsmp_pkg;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLLISION = 1'd1;

    // output queue: one fired sample can add two words
    localparam int QDEPTH   = 4;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 3;

    // where the filter stands in the current scan
    typedef enum logic [1:0] {
        POS_START = 2'd0,
        POS_FIRST = 2'd1,
        POS_INNER = 2'd2
    } t_pos;

    // words written into the output queue in one cycle
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

>>> rtl/core/laser_scan_median_proximity.sv
// ----------------------------------------------------------------------------
// laser_scan_median_proximity: recursive three-tap median over laser scans
// Filters range samples in scan order and flags ranges below the collision
// distance.
// ----------------------------------------------------------------------------
// One sample is taken per clock. A sample is registered, then the median of
// the previous filtered value, the held sample and the new sample, plus the
// obstacle compare, are worked out combinationally and written into a
// four-entry output queue; the words a sample gives pass through the input
// register and the queue before they reach the result channel.
// Results lag the input by one sample: the first sample of a scan gives no
// word until the next one arrives, and the last sample gives two words. The
// output channel moves one word per cycle when not stalled; N samples of a
// scan give N words. The input is stalled only while the queue has no room
// for two words. Invalid samples are replaced by register 0 (max range);
// register 1 is the collision distance. Write registers only while idle.
// ----------------------------------------------------------------------------
module laser_scan_median_proximity
    import lsmp_pkg::*;
#(
    parameter int RANGE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [RANGE_BITS-1:0] i_sample_mm,
    input  logic                  i_sample_valid,
    input  logic                  i_scan_end,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [RANGE_BITS-1:0] o_filtered_mm,
    output logic                  o_obstacle_seen,
    output logic                  o_scan_done,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int WORD_W = RANGE_BITS + 2;

    t_push               push;
    logic [WORD_W-1:0]   word0;
    logic [WORD_W-1:0]   word1;
    logic [WORD_W-1:0]   word_out;
    logic                room;
    logic [Q_CNT_W-1:0]  q_count;

    lsmp_core #(
        .RANGE_BITS (RANGE_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_mm    (i_sample_mm),
        .i_sample_valid (i_sample_valid),
        .i_scan_end     (i_scan_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_room         (room),
        .o_push         (push),
        .o_word0        (word0),
        .o_word1        (word1)
    );

    lsmp_outq #(
        .WIDTH (WORD_W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word0 (word0),
        .i_word1 (word1),
        .o_room  (room),
        .o_count (q_count),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (word_out)
    );

    assign o_filtered_mm   = word_out[WORD_W-1:2];
    assign o_obstacle_seen = word_out[1];
    assign o_scan_done     = word_out[0];

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= Q_CNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.second |-> push.first)
        else $error("second word pushed without first");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.first |-> room)
        else $error("word pushed without queue room");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_obstacle_seen && !o_scan_done)
        |=> (!o_valid || o_obstacle_seen))
        else $error("obstacle flag dropped inside a scan");

endmodule

>>> rtl/core/lsmp_core.sv
// ----------------------------------------------------------------------------
// lsmp_core: input register, scan state and three-tap median
// Holds the configuration, registers the incoming sample and turns it into
// zero, one or two result words for the output queue.
// ----------------------------------------------------------------------------
module lsmp_core
    import lsmp_pkg::*;
#(
    parameter int RANGE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [RANGE_BITS-1:0] i_sample_mm,
    input  logic                  i_sample_valid,
    input  logic                  i_scan_end,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // output queue side
    input  logic                  i_room,
    output t_push                 o_push,
    output logic [RANGE_BITS+1:0] o_word0,
    output logic [RANGE_BITS+1:0] o_word1
);

    logic [RANGE_BITS-1:0] r_max_range;
    logic [RANGE_BITS-1:0] r_collision;
    logic [RANGE_BITS-1:0] n_cfg_val;

    logic                  r_in_v;
    logic [RANGE_BITS-1:0] r_in_mm;
    logic                  r_in_ok;
    logic                  r_in_last;

    t_pos                  r_pos,  n_pos;
    logic                  r_flag, n_flag;
    logic [RANGE_BITS-1:0] r_prev, n_prev;
    logic [RANGE_BITS-1:0] r_pend, n_pend;

    logic                  accept;
    logic                  fire;
    logic [RANGE_BITS-1:0] smp;
    logic [RANGE_BITS-1:0] med;
    logic [RANGE_BITS-1:0] v0;
    logic                  f0;
    logic                  f1;

    function automatic logic [RANGE_BITS-1:0] med3(
        input logic [RANGE_BITS-1:0] a,
        input logic [RANGE_BITS-1:0] b,
        input logic [RANGE_BITS-1:0] c
    );
        logic [RANGE_BITS-1:0] lo;
        logic [RANGE_BITS-1:0] hi;
        logic [RANGE_BITS-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // register data is zero extended or truncated to the range width
    always_comb begin
        n_cfg_val = '0;
        for (int i = 0; i < RANGE_BITS && i < CFG_W; i++) begin
            n_cfg_val[i] = i_cfg_data[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= RANGE_BITS'(32'd65535);
            r_collision <= RANGE_BITS'(32'd1000);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MAX_RANGE) begin
                r_max_range <= n_cfg_val;
            end
            if (i_cfg_idx == REG_COLLISION) begin
                r_collision <= n_cfg_val;
            end
        end
    end

    // input register
    assign fire    = r_in_v && i_room;
    assign o_stall = r_in_v && !i_room;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (accept) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_mm   <= i_sample_mm;
            r_in_ok   <= i_sample_valid;
            r_in_last <= i_scan_end;
        end
    end

    assign smp = r_in_ok ? r_in_mm : r_max_range;
    assign med = med3(r_prev, r_pend, smp);
    assign v0  = (r_pos == POS_FIRST) ? r_pend : med;
    assign f0  = r_flag || (v0 < r_collision);
    assign f1  = f0 || (smp < r_collision);

    always_comb begin
        n_pos   = r_pos;
        n_flag  = r_flag;
        n_prev  = r_prev;
        n_pend  = r_pend;
        o_push  = '0;
        o_word0 = {v0, f0, 1'b0};
        o_word1 = {smp, f1, 1'b1};
        if (fire) begin
            unique case (r_pos)
                POS_START: begin
                    // flag starts fresh with each scan
                    o_word0 = {smp, smp < r_collision, 1'b1};
                    n_flag  = r_in_last && (smp < r_collision);
                    if (r_in_last) begin
                        o_push.first = 1'b1;
                    end else begin
                        n_pend = smp;
                        n_pos  = POS_FIRST;
                    end
                end
                default: begin
                    n_prev       = v0;
                    o_push.first = 1'b1;
                    if (r_in_last) begin
                        // last sample passes through unchanged
                        o_push.second = 1'b1;
                        n_flag        = f1;
                        n_pos         = POS_START;
                    end else begin
                        n_flag = f0;
                        n_pend = smp;
                        n_pos  = POS_INNER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_START;
            r_flag <= 1'b0;
            r_prev <= '0;
            r_pend <= '0;
        end else begin
            r_pos  <= n_pos;
            r_flag <= n_flag;
            r_prev <= n_prev;
            r_pend <= n_pend;
        end
    end

endmodule

>>> rtl/core/lsmp_outq.sv
// ----------------------------------------------------------------------------
// lsmp_outq: four-entry result queue
// Takes up to two words a cycle from the filter core and hands them out one
// at a time on the result channel.
// ----------------------------------------------------------------------------
module lsmp_outq
    import lsmp_pkg::*;
#(
    parameter int WIDTH = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_push              i_push,
    input  logic [WIDTH-1:0]   i_word0,
    input  logic [WIDTH-1:0]   i_word1,
    output logic               o_room,
    output logic [Q_CNT_W-1:0] o_count,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WIDTH-1:0]   o_word
);

    logic [WIDTH-1:0]   r_mem [QDEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_word  = r_mem[r_rd];
    assign o_count = r_count;
    // room for the two words of a scan end
    assign o_room  = (r_count <= Q_CNT_W'(QDEPTH - 2));

    always_comb begin
        n_wr    = r_wr + Q_PTR_W'(i_push.first) + Q_PTR_W'(i_push.second);
        n_count = r_count + Q_CNT_W'(i_push.first) + Q_CNT_W'(i_push.second)
                  - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_word0;
        end
        if (i_push.second) begin
            r_mem[r_wr + Q_PTR_W'(1)] <= i_word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= n_count;
            if (pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
        end
    end

endmodule

>>> tb/tb_laser_scan_median_proximity.sv
// ----------------------------------------------------------------------------
// tb_laser_scan_median_proximity: self-checking bench for the scan median filter
// Sends scripted scans and then random scans of random length under several
// register settings, with random idles on both channels. Every result word is
// checked against a cycle-free predictor of the recursive three-tap median
// and the sticky obstacle flag.
// ----------------------------------------------------------------------------
module tb_laser_scan_median_proximity;
    import lsmp_pkg::*;

    localparam int RANGE_BITS    = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int PRINT_LIMIT   = 40;
    localparam int SCRIPT_ROWS   = 24;

    typedef struct packed {
        logic [RANGE_BITS-1:0] mm;
        logic                  obst;
        logic                  done;
    } t_result;

    typedef struct packed {
        logic [RANGE_BITS-1:0] mm;
        logic                  ok;
        logic                  last;
        logic                  fixed;
        logic [RANGE_BITS-1:0] want_mm;
        logic                  want_obst;
    } t_row;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic [RANGE_BITS-1:0] i_sample_mm    = '0;
    logic                  i_sample_valid = 1'b0;
    logic                  i_scan_end     = 1'b0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic [RANGE_BITS-1:0] o_filtered_mm;
    logic                  o_obstacle_seen;
    logic                  o_scan_done;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = REG_MAX_RANGE;
    logic [CFG_W-1:0]      i_cfg_data     = '0;

    // predictor state and register copies
    logic [RANGE_BITS-1:0] max_mm      = 16'd65535;
    logic [RANGE_BITS-1:0] near_mm     = 16'd1000;
    logic [RANGE_BITS-1:0] held_mm     = '0;
    logic [RANGE_BITS-1:0] last_out_mm = '0;
    t_pos                  scan_pos    = POS_START;
    logic                  obst_flag   = 1'b0;

    t_result filtered_due[$];
    t_row    scripted [SCRIPT_ROWS];
    logic [RANGE_BITS-1:0] drift_mm = 16'd4000;
    bit      calm = 1'b0;
    int      mismatches = 0;
    int      words_seen = 0;
    int      quiet_cycles = 0;

    laser_scan_median_proximity #(
        .RANGE_BITS(RANGE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_mm    (i_sample_mm),
        .i_sample_valid (i_sample_valid),
        .i_scan_end     (i_scan_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_filtered_mm  (o_filtered_mm),
        .o_obstacle_seen(o_obstacle_seen),
        .o_scan_done    (o_scan_done),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [RANGE_BITS-1:0] median3(input logic [RANGE_BITS-1:0] a,
                                                      input logic [RANGE_BITS-1:0] b,
                                                      input logic [RANGE_BITS-1:0] c);
        logic [RANGE_BITS-1:0] lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c >= hi) return hi;
        if (c <= lo) return lo;
        return c;
    endfunction

    function automatic void queue_result(input logic [RANGE_BITS-1:0] v, input logic done);
        t_result r;
        if (v < near_mm) obst_flag = 1'b1;
        r.mm   = v;
        r.obst = obst_flag;
        r.done = done;
        filtered_due.push_back(r);
    endfunction

    // one accepted sample: results lag by one sample, the scan end flushes two
    function automatic void predict_sample(input logic [RANGE_BITS-1:0] mm, input logic ok,
                                           input logic last);
        logic [RANGE_BITS-1:0] s;
        s = ok ? mm : max_mm;
        if (scan_pos == POS_START) begin
            obst_flag = 1'b0;
            if (last) begin
                queue_result(s, 1'b1);
            end else begin
                held_mm  = s;
                scan_pos = POS_FIRST;
            end
        end else begin
            if (scan_pos == POS_FIRST) last_out_mm = held_mm;
            else last_out_mm = median3(last_out_mm, held_mm, s);
            queue_result(last_out_mm, 1'b0);
            if (last) begin
                queue_result(s, 1'b1);
                scan_pos = POS_START;
            end else begin
                held_mm  = s;
                scan_pos = POS_INNER;
            end
        end
    endfunction

    function automatic logic [RANGE_BITS-1:0] pick_mm();
        int v;
        case ($urandom_range(9))
            0:       v = $urandom_range(1) ? 0 : 65535;
            1:       v = int'(near_mm) + int'($urandom_range(4)) - 2;
            2, 3, 4: v = int'($urandom_range(65535));
            default: v = int'(drift_mm) + int'($urandom_range(600)) - 300;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        drift_mm = v[RANGE_BITS-1:0];
        return v[RANGE_BITS-1:0];
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch %s at word %0d: got %0d want %0d", what, words_seen, got, want);
        mismatches++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_sample(input logic [RANGE_BITS-1:0] mm, input logic ok,
                               input logic last, input logic fixed, input t_result fixed_word);
        while (!calm && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_mm    <= mm;
        i_sample_valid <= ok;
        i_scan_end     <= last;
        do @(posedge i_clk); while (o_stall);
        predict_sample(mm, ok, last);
        if (fixed) filtered_due[filtered_due.size()-1] = fixed_word;
        @(negedge i_clk);
    endtask

    // sender holds off until every due word is out, then lets the pipe empty
    task automatic settle();
        i_valid <= 1'b0;
        while (filtered_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MAX_RANGE: max_mm  = val[RANGE_BITS-1:0];
            REG_COLLISION: near_mm = val[RANGE_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // whole scans only, so a phase always ends on a scan boundary
    task automatic random_scans(input int count);
        int sent, len, r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 10) len = 1;
            else if (r < 20) len = 2;
            else if (r < 85) len = $urandom_range(3, 10);
            else len = $urandom_range(11, 60);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(299) == 0) settle();
                send_sample(pick_mm(), $urandom_range(99) < 85, k == len - 1, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 8);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (filtered_due.size() == 0) begin
                flag_mismatch("word with none due", o_filtered_mm, 0);
            end else begin
                want = filtered_due.pop_front();
                if (o_filtered_mm !== want.mm)
                    flag_mismatch("filtered_mm", o_filtered_mm, want.mm);
                if (o_obstacle_seen !== want.obst)
                    flag_mismatch("obstacle_seen", o_obstacle_seen, want.obst);
                if (o_scan_done !== want.done)
                    flag_mismatch("scan_done", o_scan_done, want.done);
            end
            words_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [CFG_W-1:0] cfg_max, cfg_near;
        t_result          fixed_word;

        // default registers: max range 65535, collision distance 1000
        scripted = '{
            // one-sample scans, the flag clears at each scan start
            '{16'd123,   1'b1, 1'b1, 1'b1, 16'd123,   1'b1},
            '{16'd5000,  1'b1, 1'b1, 1'b1, 16'd5000,  1'b0},
            '{16'd0,     1'b0, 1'b1, 1'b1, 16'd65535, 1'b0},
            // two-sample scan passes through
            '{16'd0,     1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd65535, 1'b1, 1'b1, 1'b1, 16'd65535, 1'b1},
            // a short spike is removed
            '{16'd2000,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd100,   1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd3000,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd2500,  1'b1, 1'b1, 1'b1, 16'd2500,  1'b0},
            // invalid words inside and at the end of a scan
            '{16'd1500,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd0,     1'b0, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd1200,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd65535, 1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd65535, 1'b0, 1'b1, 1'b1, 16'd65535, 1'b0},
            // obstacle stays set for the rest of the scan
            '{16'd900,   1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd800,   1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd5000,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd5000,  1'b1, 1'b1, 1'b1, 16'd5000,  1'b1},
            // compare is strictly below the distance
            '{16'd1000,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'd999,   1'b1, 1'b1, 1'b1, 16'd999,   1'b1},
            // alternating bit patterns
            '{16'hAAAA,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'h5555,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'hFFFF,  1'b1, 1'b0, 1'b0, 16'd0,     1'b0},
            '{16'h0000,  1'b1, 1'b1, 1'b1, 16'h0000,  1'b1}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int row = 0; row < SCRIPT_ROWS; row++) begin
            fixed_word = '{scripted[row].want_mm, scripted[row].want_obst, 1'b1};
            send_sample(scripted[row].mm, scripted[row].ok, scripted[row].last,
                        scripted[row].fixed, fixed_word);
        end

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin cfg_max = 16'd0;     cfg_near = 16'd0;     end
                1: begin cfg_max = 16'd65535; cfg_near = 16'd65535; end
                3: begin cfg_max = 16'd3000;  cfg_near = 16'd1500;  end
                4: begin cfg_max = 16'd65535; cfg_near = 16'd1;     end
                default: begin
                    cfg_max  = CFG_W'($urandom_range(65535));
                    cfg_near = CFG_W'($urandom_range(65535));
                end
            endcase
            calm = (ph == 2);
            write_reg(REG_MAX_RANGE, cfg_max);
            write_reg(REG_COLLISION, cfg_near);
            random_scans(215);
        end

        settle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
